FILE: rtl/core/hta_pkg.sv
// shared types and constants for the hysteresis threshold alarm
// no dependencies
package hta_pkg;

  localparam int TEMP_W   = 15;
  localparam int HUM_W    = 14;
  localparam int VAL_W    = 17;
  localparam int CFG_W    = 15;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_CH   = 4;
  localparam int REPORT_W = 16;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = NUM_CH * REPORT_W;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_TEMP_HIGH_LIMIT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_LOW_LIMIT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_HYST          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_HIGH_LIMIT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_LOW_LIMIT      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_HYST           = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_ENABLE     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_LATCH_MODE = 3'd7;

  localparam logic signed [TEMP_W-1:0] TEMP_HIGH_LIMIT_RST = 15'sd2500;
  localparam logic signed [TEMP_W-1:0] TEMP_LOW_LIMIT_RST  = 15'sd2500;
  localparam logic [TEMP_W-1:0]        TEMP_HYST_RST       = 15'd500;
  localparam logic [HUM_W-1:0]         HUM_HIGH_LIMIT_RST  = 14'd8000;
  localparam logic [HUM_W-1:0]         HUM_LOW_LIMIT_RST   = 14'd2000;
  localparam logic [HUM_W-1:0]         HUM_HYST_RST        = 14'd500;
  localparam logic [NUM_CH-1:0]        CHANNEL_ENABLE_RST  = 4'h0;
  localparam logic [NUM_CH-1:0]        LATCH_MODE_RST      = 4'hf;

  typedef enum logic [1:0] {
    PH_NORMAL  = 2'd0,
    PH_OUTSIDE = 2'd1,
    PH_INSIDE  = 2'd2
  } phase_t;

  typedef struct packed {
    logic sample_en;
    logic read_clr;
  } ch_ctrl_t;

endpackage

FILE: rtl/core/hta_channel.sv
// one alarm channel: phase machine, alarm latch and saturating event count
// depends on hta_pkg
module hta_channel #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  hta_pkg::ch_ctrl_t                     ctrl,
  input  logic                                  high_side,
  input  logic signed [hta_pkg::VAL_W-1:0]      value,
  input  logic signed [hta_pkg::VAL_W-1:0]      thr,
  input  logic signed [hta_pkg::VAL_W-1:0]      hyst,
  output logic                                  latch,
  output logic [hta_pkg::REPORT_W-1:0]          count_report
);

  localparam int RW = (COUNT_WIDTH > hta_pkg::REPORT_W) ? COUNT_WIDTH : hta_pkg::REPORT_W;

  hta_pkg::phase_t phase, phase_next;
  logic [COUNT_WIDTH-1:0] count;
  logic [RW-1:0] count_ext;
  logic signed [hta_pkg::VAL_W-1:0] bound;
  logic beyond, cleared, evt, latch_clr;

  always_comb begin
    bound   = high_side ? (thr - hyst) : (thr + hyst);
    beyond  = high_side ? (value >= thr) : (value <= thr);
    cleared = high_side ? (value <= bound) : (value >= bound);
  end

  always_comb begin
    phase_next = phase;
    if (ctrl.sample_en) begin
      case (phase)
        hta_pkg::PH_OUTSIDE: begin
          if (!beyond) phase_next = hta_pkg::PH_INSIDE;
        end
        hta_pkg::PH_INSIDE: begin
          if (cleared) phase_next = hta_pkg::PH_NORMAL;
          else if (beyond) phase_next = hta_pkg::PH_OUTSIDE;
        end
        default: begin
          phase_next = beyond ? hta_pkg::PH_OUTSIDE : hta_pkg::PH_NORMAL;
        end
      endcase
    end
  end

  always_comb begin
    evt       = 1'b0;
    latch_clr = 1'b0;
    if (ctrl.sample_en) begin
      case (phase)
        hta_pkg::PH_OUTSIDE: ;
        hta_pkg::PH_INSIDE: latch_clr = cleared;
        default: evt = beyond;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= hta_pkg::PH_NORMAL;
      latch <= 1'b0;
      count <= '0;
    end else begin
      phase <= phase_next;
      if (evt) latch <= 1'b1;
      else if (latch_clr) latch <= 1'b0;
      if (ctrl.read_clr) count <= '0;
      else if (evt && (count != {COUNT_WIDTH{1'b1}})) count <= count + 1'b1;
    end
  end

  // report saturates at the report width
  always_comb begin
    count_ext = RW'(count);
    if (count_ext > RW'(32'h0000_ffff)) count_report = '1;
    else count_report = count_ext[hta_pkg::REPORT_W-1:0];
  end

endmodule

FILE: rtl/core/hysteresis_threshold_alarm_core.sv
// four-channel threshold alarm with hysteresis, top level
// depends on hta_pkg and hta_channel
// a read beat's result comes out of the input register through the result register
// throughput: one beat per cycle unless a read beat waits, set by the input register and the result register
// sample beats give no result; a read beat waits only while the result register is full and not taken
// reset: synchronous, restores register defaults, all phases normal, latches and counts clear
module hysteresis_threshold_alarm_core #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // temperature [14:0], humidity [28:15], zero fill [31:29]
  input  logic [hta_pkg::IN_DATA_W-1:0]          s_axis_tdata,
  // op
  input  logic                                   s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // temp_high_report, temp_low_report, hum_high_report, hum_low_report
  output logic [hta_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
  input  logic                                   cfg_we,
  input  logic [hta_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [hta_pkg::CFG_W-1:0]              cfg_data
);

  localparam int NCH = hta_pkg::NUM_CH;
  localparam int RPW = hta_pkg::REPORT_W;

  logic signed [hta_pkg::TEMP_W-1:0] temp_high_limit, temp_low_limit;
  logic [hta_pkg::TEMP_W-1:0]        temp_hyst;
  logic [hta_pkg::HUM_W-1:0]         hum_high_limit, hum_low_limit, hum_hyst;
  logic [NCH-1:0]                    channel_enable, channel_latch_mode;

  logic                              in_valid;
  logic                              in_op;
  logic [hta_pkg::TEMP_W-1:0]        in_temp;
  logic [hta_pkg::HUM_W-1:0]         in_hum;
  logic                              out_free, adv;

  logic signed [hta_pkg::VAL_W-1:0]  ch_value [NCH];
  logic signed [hta_pkg::VAL_W-1:0]  ch_thr   [NCH];
  logic signed [hta_pkg::VAL_W-1:0]  ch_hyst  [NCH];
  hta_pkg::ch_ctrl_t                 ch_ctrl  [NCH];
  logic [NCH-1:0]                    ch_latch;
  logic [RPW-1:0]                    ch_count [NCH];
  logic [hta_pkg::OUT_DATA_W-1:0]    report;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_high_limit    <= hta_pkg::TEMP_HIGH_LIMIT_RST;
      temp_low_limit     <= hta_pkg::TEMP_LOW_LIMIT_RST;
      temp_hyst          <= hta_pkg::TEMP_HYST_RST;
      hum_high_limit     <= hta_pkg::HUM_HIGH_LIMIT_RST;
      hum_low_limit      <= hta_pkg::HUM_LOW_LIMIT_RST;
      hum_hyst           <= hta_pkg::HUM_HYST_RST;
      channel_enable     <= hta_pkg::CHANNEL_ENABLE_RST;
      channel_latch_mode <= hta_pkg::LATCH_MODE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        hta_pkg::REG_TEMP_HIGH_LIMIT:    temp_high_limit    <= cfg_data;
        hta_pkg::REG_TEMP_LOW_LIMIT:     temp_low_limit     <= cfg_data;
        hta_pkg::REG_TEMP_HYST:          temp_hyst          <= cfg_data;
        hta_pkg::REG_HUM_HIGH_LIMIT:     hum_high_limit     <= cfg_data[hta_pkg::HUM_W-1:0];
        hta_pkg::REG_HUM_LOW_LIMIT:      hum_low_limit      <= cfg_data[hta_pkg::HUM_W-1:0];
        hta_pkg::REG_HUM_HYST:           hum_hyst           <= cfg_data[hta_pkg::HUM_W-1:0];
        hta_pkg::REG_CHANNEL_ENABLE:     channel_enable     <= cfg_data[NCH-1:0];
        hta_pkg::REG_CHANNEL_LATCH_MODE: channel_latch_mode <= cfg_data[NCH-1:0];
        default: ;
      endcase
    end
  end

  // input register
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign adv           = in_valid && ((in_op == hta_pkg::OP_SAMPLE) || out_free);
  assign s_axis_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op   <= s_axis_tuser;
      in_temp <= s_axis_tdata[hta_pkg::TEMP_W-1:0];
      in_hum  <= s_axis_tdata[hta_pkg::TEMP_W +: hta_pkg::HUM_W];
    end
  end

  // channel operands: temp high, temp low, hum high, hum low
  always_comb begin
    ch_value[0] = {{2{in_temp[hta_pkg::TEMP_W-1]}}, in_temp};
    ch_value[1] = ch_value[0];
    ch_value[2] = {3'b000, in_hum};
    ch_value[3] = ch_value[2];
    ch_thr[0]   = {{2{temp_high_limit[hta_pkg::TEMP_W-1]}}, temp_high_limit};
    ch_thr[1]   = {{2{temp_low_limit[hta_pkg::TEMP_W-1]}}, temp_low_limit};
    ch_thr[2]   = {3'b000, hum_high_limit};
    ch_thr[3]   = {3'b000, hum_low_limit};
    ch_hyst[0]  = {2'b00, temp_hyst};
    ch_hyst[1]  = {2'b00, temp_hyst};
    ch_hyst[2]  = {3'b000, hum_hyst};
    ch_hyst[3]  = {3'b000, hum_hyst};
  end

  for (genvar i = 0; i < NCH; i++) begin : g_ch
    always_comb begin
      ch_ctrl[i].sample_en = adv && (in_op == hta_pkg::OP_SAMPLE) && channel_enable[i];
      ch_ctrl[i].read_clr  = adv && (in_op == hta_pkg::OP_READ);
    end

    hta_channel #(
      .COUNT_WIDTH(COUNT_WIDTH)
    ) u_channel (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (ch_ctrl[i]),
      .high_side    ((i % 2) == 0),
      .value        (ch_value[i]),
      .thr          (ch_thr[i]),
      .hyst         (ch_hyst[i]),
      .latch        (ch_latch[i]),
      .count_report (ch_count[i])
    );

    assign report[i*RPW +: RPW] = channel_latch_mode[i] ? RPW'(ch_latch[i]) : ch_count[i];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv && (in_op == hta_pkg::OP_READ)) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && (in_op == hta_pkg::OP_READ)) m_axis_tdata <= report;
  end

  a_read_gives_result: assert property (@(posedge clk) disable iff (rst)
    (adv && (in_op == hta_pkg::OP_READ)) |=> m_axis_tvalid)
    else $error("read beat did not produce a result");

  a_read_clears_counts: assert property (@(posedge clk) disable iff (rst)
    (adv && (in_op == hta_pkg::OP_READ)) |=>
      (ch_count[0] == '0) && (ch_count[1] == '0) && (ch_count[2] == '0) && (ch_count[3] == '0))
    else $error("event counts not cleared by read");

  a_sample_keeps_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && (in_op == hta_pkg::OP_SAMPLE) && m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("sample beat disturbed a pending result");

  a_stalled_read_waits: assert property (@(posedge clk) disable iff (rst)
    (in_valid && (in_op == hta_pkg::OP_READ) && m_axis_tvalid && !m_axis_tready) |-> !adv)
    else $error("read beat advanced into a full result register");

endmodule

FILE: test/hta_report_check.sv
// checker for the threshold alarm: watches config writes and both stream sides
// keeps its own copy of channel state and compares every report beat in order
// depends on hta_pkg
`timescale 1ns / 100ps

module hta_report_check #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  // temperature [14:0], humidity [28:15], zero fill [31:29]
  input  logic [hta_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // op
  input  logic                            s_axis_tuser,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // temp_high_report, temp_low_report, hum_high_report, hum_low_report
  input  logic [hta_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic                            cfg_we,
  input  logic [hta_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hta_pkg::CFG_W-1:0]       cfg_data,
  output int unsigned                     reports_waiting,
  output int unsigned                     error_count
);

  int temp_high_thr, temp_low_thr, temp_band;
  int hum_high_thr, hum_low_thr, hum_band;
  logic [hta_pkg::NUM_CH-1:0] enabled;
  logic [hta_pkg::NUM_CH-1:0] latch_view;

  hta_pkg::phase_t        ch_phase [hta_pkg::NUM_CH];
  logic                   ch_latched [hta_pkg::NUM_CH];
  logic [COUNT_WIDTH-1:0] ch_events [hta_pkg::NUM_CH];

  logic [hta_pkg::OUT_DATA_W-1:0] due_reports [$];
  logic [hta_pkg::OUT_DATA_W-1:0] want;

  string ch_label [hta_pkg::NUM_CH] = '{"temp_high_report", "temp_low_report",
                                        "hum_high_report", "hum_low_report"};

  task automatic flag_mismatch(input string what);
    if (error_count < 50) $display("mismatch at %0t: %s", $time, what);
    error_count++;
  endtask

  function automatic void restore_defaults();
    temp_high_thr = int'(hta_pkg::TEMP_HIGH_LIMIT_RST);
    temp_low_thr  = int'(hta_pkg::TEMP_LOW_LIMIT_RST);
    temp_band     = int'(hta_pkg::TEMP_HYST_RST);
    hum_high_thr  = int'(hta_pkg::HUM_HIGH_LIMIT_RST);
    hum_low_thr   = int'(hta_pkg::HUM_LOW_LIMIT_RST);
    hum_band      = int'(hta_pkg::HUM_HYST_RST);
    enabled       = hta_pkg::CHANNEL_ENABLE_RST;
    latch_view    = hta_pkg::LATCH_MODE_RST;
    for (int i = 0; i < hta_pkg::NUM_CH; i++) begin
      ch_phase[i]   = hta_pkg::PH_NORMAL;
      ch_latched[i] = 1'b0;
      ch_events[i]  = '0;
    end
  endfunction

  function automatic void write_setting(input logic [hta_pkg::CFG_IDX_W-1:0] idx,
                                        input logic [hta_pkg::CFG_W-1:0] val);
    case (idx)
      hta_pkg::REG_TEMP_HIGH_LIMIT:    temp_high_thr = int'($signed(val));
      hta_pkg::REG_TEMP_LOW_LIMIT:     temp_low_thr = int'($signed(val));
      hta_pkg::REG_TEMP_HYST:          temp_band = int'(val);
      hta_pkg::REG_HUM_HIGH_LIMIT:     hum_high_thr = int'(val[hta_pkg::HUM_W-1:0]);
      hta_pkg::REG_HUM_LOW_LIMIT:      hum_low_thr = int'(val[hta_pkg::HUM_W-1:0]);
      hta_pkg::REG_HUM_HYST:           hum_band = int'(val[hta_pkg::HUM_W-1:0]);
      hta_pkg::REG_CHANNEL_ENABLE:     enabled = val[hta_pkg::NUM_CH-1:0];
      hta_pkg::REG_CHANNEL_LATCH_MODE: latch_view = val[hta_pkg::NUM_CH-1:0];
      default: ;
    endcase
  endfunction

  function automatic void step_channel(input int ch, input bit upper, input int v,
                                       input int thr, input int band);
    bit beyond;
    bit cleared;
    beyond  = upper ? (v >= thr) : (v <= thr);
    cleared = upper ? (v <= thr - band) : (v >= thr + band);
    case (ch_phase[ch])
      hta_pkg::PH_OUTSIDE: begin
        if (!beyond) ch_phase[ch] = hta_pkg::PH_INSIDE;
      end
      hta_pkg::PH_INSIDE: begin
        if (cleared) begin
          ch_latched[ch] = 1'b0;
          ch_phase[ch]   = hta_pkg::PH_NORMAL;
        end else if (beyond) begin
          ch_phase[ch] = hta_pkg::PH_OUTSIDE;
        end
      end
      default: begin
        ch_phase[ch] = hta_pkg::PH_NORMAL;
        if (beyond) begin
          if (ch_events[ch] != {COUNT_WIDTH{1'b1}}) ch_events[ch] = ch_events[ch] + 1'b1;
          ch_latched[ch] = 1'b1;
          ch_phase[ch]   = hta_pkg::PH_OUTSIDE;
        end
      end
    endcase
  endfunction

  function automatic void evaluate_sample(input logic [hta_pkg::TEMP_W-1:0] t,
                                          input logic [hta_pkg::HUM_W-1:0] h);
    int tv;
    int hv;
    tv = int'($signed(t));
    hv = int'(h);
    if (enabled[0]) step_channel(0, 1'b1, tv, temp_high_thr, temp_band);
    if (enabled[1]) step_channel(1, 1'b0, tv, temp_low_thr, temp_band);
    if (enabled[2]) step_channel(2, 1'b1, hv, hum_high_thr, hum_band);
    if (enabled[3]) step_channel(3, 1'b0, hv, hum_low_thr, hum_band);
  endfunction

  function automatic logic [hta_pkg::OUT_DATA_W-1:0] read_reports();
    logic [hta_pkg::OUT_DATA_W-1:0] word;
    logic [hta_pkg::REPORT_W-1:0]   r;
    for (int i = 0; i < hta_pkg::NUM_CH; i++) begin
      if (latch_view[i]) r = hta_pkg::REPORT_W'(ch_latched[i]);
      else if (ch_events[i] > 65535) r = '1;
      else r = hta_pkg::REPORT_W'(ch_events[i]);
      word[i*hta_pkg::REPORT_W +: hta_pkg::REPORT_W] = r;
      ch_events[i] = '0;
    end
    return word;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      restore_defaults();
      due_reports.delete();
      reports_waiting <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_reports.size() == 0) begin
          flag_mismatch("report beat with nothing expected");
        end else begin
          want = due_reports.pop_front();
          for (int i = 0; i < hta_pkg::NUM_CH; i++) begin
            if (m_axis_tdata[i*hta_pkg::REPORT_W +: hta_pkg::REPORT_W] !==
                want[i*hta_pkg::REPORT_W +: hta_pkg::REPORT_W])
              flag_mismatch($sformatf("%s got %0d want %0d", ch_label[i],
                m_axis_tdata[i*hta_pkg::REPORT_W +: hta_pkg::REPORT_W],
                want[i*hta_pkg::REPORT_W +: hta_pkg::REPORT_W]));
          end
        end
      end
      if (cfg_we) write_setting(cfg_index, cfg_data);
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == hta_pkg::OP_READ) due_reports.push_back(read_reports());
        else evaluate_sample(s_axis_tdata[hta_pkg::TEMP_W-1:0],
                             s_axis_tdata[hta_pkg::TEMP_W +: hta_pkg::HUM_W]);
      end
      reports_waiting <= due_reports.size();
    end
  end

endmodule

FILE: test/tb.sv
// top of the threshold alarm testbench: clock, reset, config writes and stream stimulus
// depends on hta_pkg, hysteresis_threshold_alarm_core and hta_report_check
`timescale 1ns / 100ps

module tb;

  localparam int COUNT_WIDTH  = 16;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 1500000;
  localparam int BURST_ROUNDS = 5;
  localparam int RANDOM_ITEMS = 165;

  logic                            clk;
  logic                            rst;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  // temperature [14:0], humidity [28:15], zero fill [31:29]
  logic [hta_pkg::IN_DATA_W-1:0]   s_axis_tdata;
  // op
  logic                            s_axis_tuser;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  // temp_high_report, temp_low_report, hum_high_report, hum_low_report
  logic [hta_pkg::OUT_DATA_W-1:0]  m_axis_tdata;
  logic                            cfg_we;
  logic [hta_pkg::CFG_IDX_W-1:0]   cfg_index;
  logic [hta_pkg::CFG_W-1:0]       cfg_data;

  int unsigned reports_waiting;
  int unsigned error_count;
  int unsigned cycle_count;

  int send_idle;
  int recv_idle;
  int hold_reqs;
  int hold_seen;
  int hold_left;

  int lim_th, lim_tl, band_t, lim_hh, lim_hl, band_h;

  hysteresis_threshold_alarm_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  hta_report_check #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) alarm_check (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .reports_waiting(reports_waiting),
    .error_count(error_count)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // receiver: random stalls plus one long hold-off on request
  initial begin
    hold_seen = 0;
    hold_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic send_item(input logic op, input int temp, input int hum);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {3'b000, hum[hta_pkg::HUM_W-1:0], temp[hta_pkg::TEMP_W-1:0]};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (reports_waiting != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic put_reg(input logic [hta_pkg::CFG_IDX_W-1:0] idx,
                         input logic [hta_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic configure(input int t_hi, input int t_lo, input int t_band, input int h_hi,
                           input int h_lo, input int h_band, input int en, input int mode);
    lim_th = t_hi;
    lim_tl = t_lo;
    band_t = t_band;
    lim_hh = h_hi;
    lim_hl = h_lo;
    band_h = h_band;
    put_reg(hta_pkg::REG_TEMP_HIGH_LIMIT, t_hi[hta_pkg::CFG_W-1:0]);
    put_reg(hta_pkg::REG_TEMP_LOW_LIMIT, t_lo[hta_pkg::CFG_W-1:0]);
    put_reg(hta_pkg::REG_TEMP_HYST, t_band[hta_pkg::CFG_W-1:0]);
    put_reg(hta_pkg::REG_HUM_HIGH_LIMIT, {1'b0, h_hi[hta_pkg::HUM_W-1:0]});
    put_reg(hta_pkg::REG_HUM_LOW_LIMIT, {1'b0, h_lo[hta_pkg::HUM_W-1:0]});
    put_reg(hta_pkg::REG_HUM_HYST, {1'b0, h_band[hta_pkg::HUM_W-1:0]});
    put_reg(hta_pkg::REG_CHANNEL_ENABLE, {11'b0, en[hta_pkg::NUM_CH-1:0]});
    put_reg(hta_pkg::REG_CHANNEL_LATCH_MODE, {11'b0, mode[hta_pkg::NUM_CH-1:0]});
    cfg_we <= 1'b0;
  endtask

  function automatic int rand_in(input int lo, input int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // mostly values right at the threshold and hysteresis edges
  function automatic int pick_level(input int thr, input int band, input int lo, input int hi);
    case ($urandom_range(11))
      0: return thr;
      1: return thr - 1;
      2: return thr + 1;
      3: return thr - band;
      4: return thr + band;
      5: return thr - band - 1;
      6: return thr + band + 1;
      7, 8: return thr - band - 50 + int'($urandom_range(2 * band + 100));
      9: return rand_in(lo, hi);
      default: return int'($urandom);
    endcase
  endfunction

  task automatic send_random_item();
    int t;
    int h;
    if ($urandom_range(99) < 15) begin
      send_item(hta_pkg::OP_READ, int'($urandom), int'($urandom));
    end else begin
      t = $urandom_range(1) ? pick_level(lim_th, band_t, -4000, 15000)
                            : pick_level(lim_tl, band_t, -4000, 15000);
      h = $urandom_range(1) ? pick_level(lim_hh, band_h, 0, 10000)
                            : pick_level(lim_hl, band_h, 0, 10000);
      send_item(hta_pkg::OP_SAMPLE, t, h);
    end
  endtask

  task automatic random_setup(input int kind);
    int en;
    int mode;
    en   = $urandom_range(15);
    mode = $urandom_range(15);
    case (kind)
      0: configure(-16384, -16384, 0, 0, 0, 0, 15, mode);
      1: configure(16383, 16383, 32767, 16383, 16383, 16383, 15, mode);
      2: configure(15000, -4000, 19000, 10000, 0, 10000, en, mode);
      default: configure(rand_in(-4000, 15000), rand_in(-4000, 15000),
                         $urandom_range(800), $urandom_range(10000),
                         $urandom_range(10000), $urandom_range(800), en, mode);
    endcase
  endtask

  initial begin
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= hta_pkg::OP_SAMPLE;
    cfg_we        <= 1'b0;
    cfg_index     <= hta_pkg::REG_TEMP_HIGH_LIMIT;
    cfg_data      <= '0;
    send_idle = 0;
    recv_idle = 0;
    hold_reqs = 0;
    lim_th = 2500;
    lim_tl = 2500;
    band_t = 500;
    lim_hh = 8000;
    lim_hl = 2000;
    band_h = 500;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset state: every channel disabled, samples change nothing
    send_item(hta_pkg::OP_SAMPLE, 3000, 9000);
    send_item(hta_pkg::OP_READ, 0, 0);
    drain();

    configure(2500, -1000, 500, 8000, 2000, 500, 15, 4'b0101);
    send_item(hta_pkg::OP_SAMPLE, 2500, 8000);
    send_item(hta_pkg::OP_SAMPLE, 2499, 7999);
    send_item(hta_pkg::OP_SAMPLE, 2500, 8000);
    send_item(hta_pkg::OP_SAMPLE, 2001, 7501);
    send_item(hta_pkg::OP_READ, 0, 0);
    send_item(hta_pkg::OP_SAMPLE, 2000, 7500);
    send_item(hta_pkg::OP_READ, 0, 0);
    send_item(hta_pkg::OP_SAMPLE, -1000, 2000);
    send_item(hta_pkg::OP_SAMPLE, -16384, 0);
    send_item(hta_pkg::OP_SAMPLE, -501, 2499);
    send_item(hta_pkg::OP_SAMPLE, -500, 2500);
    send_item(hta_pkg::OP_READ, 0, 0);
    send_item(hta_pkg::OP_SAMPLE, 16383, 16383);
    send_item(hta_pkg::OP_SAMPLE, -4000, 0);
    send_item(hta_pkg::OP_SAMPLE, 15000, 10000);
    send_item(hta_pkg::OP_READ, -1, -1);
    drain();

    // latch mode flips, half the channels frozen
    configure(2500, -1000, 500, 8000, 2000, 500, 4'b1010, 4'b1010);
    send_item(hta_pkg::OP_READ, 0, 0);
    send_item(hta_pkg::OP_SAMPLE, 16383, 16383);
    send_item(hta_pkg::OP_SAMPLE, -16384, 0);
    send_item(hta_pkg::OP_READ, 0, 0);
    drain();

    // long receiver hold-off while reads keep coming
    configure(2500, -1000, 300, 8000, 2000, 300, 15, 4'b0011);
    hold_reqs++;
    for (int i = 0; i < 40; i++) begin
      if (i % 2 == 0) send_item(hta_pkg::OP_READ, 0, 0);
      else send_random_item();
    end
    drain();

    for (int pass_no = 0; pass_no < 3; pass_no++) begin
      case (pass_no)
        0: begin
          send_idle = 6;
          recv_idle = 45;
        end
        1: begin
          send_idle = 45;
          recv_idle = 6;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      for (int sub = 0; sub < 3; sub++) begin
        random_setup(pass_no * 3 + sub);
        repeat (RANDOM_ITEMS) send_random_item();
        drain();
      end
    end

    // repeated excursions on every channel, counted between reads
    send_idle = 0;
    recv_idle = 20;
    configure(100, -100, 0, 6000, 4000, 0, 15, 0);
    send_item(hta_pkg::OP_READ, 0, 0);
    repeat (BURST_ROUNDS) begin
      send_item(hta_pkg::OP_SAMPLE, 200, 8000);
      send_item(hta_pkg::OP_SAMPLE, 0, 5000);
      send_item(hta_pkg::OP_SAMPLE, -200, 2000);
      send_item(hta_pkg::OP_SAMPLE, 0, 5000);
    end
    send_item(hta_pkg::OP_READ, 0, 0);
    send_item(hta_pkg::OP_READ, 0, 0);
    drain();

    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/hta_pkg.sv
rtl/core/hta_channel.sv
rtl/core/hysteresis_threshold_alarm_core.sv
test/hta_report_check.sv
test/tb.sv
